/* rtl/tcmv_pkg.sv */
package tcmv_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int VALUE_W   = 32;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] element;
    logic                      element_valid;
    logic                      final_res;
    logic                      overflow;
  } out_item_t;

  // Outcome of the vote for one sequence, handed from front to back.
  typedef struct packed {
    logic signed [VALUE_W-1:0] cand_a;
    logic signed [VALUE_W-1:0] cand_b;
    logic                      overflow;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WALK,
    BK_FLUSH,
    BK_DECIDE,
    BK_EMIT,
    BK_EMIT_B
  } back_state_t;

endpackage

/* rtl/tcmv_ram.sv */
module tcmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/tcmv_queue.sv */
module tcmv_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  import tcmv_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full      = (fill_r == NW'(QUEUE_DEPTH));
  assign not_empty = (fill_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/tcmv_front.sv */
module tcmv_front #(
  parameter int DEPTH = tcmv_pkg::DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tcmv_pkg::in_item_t       in_item,
  input  logic                     hold,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [tcmv_pkg::VALUE_W-1:0] wr_data,
  output logic                     push,
  output tcmv_pkg::job_t           push_job,
  output logic [CW-1:0]            push_n
);

  import tcmv_pkg::*;

  logic signed [VALUE_W-1:0] cand_a_r, cand_a_nxt;
  logic signed [VALUE_W-1:0] cand_b_r, cand_b_nxt;
  logic [CW-1:0]             votes_a_r, votes_a_nxt;
  logic [CW-1:0]             votes_b_r, votes_b_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic                      drop_r, drop_nxt;

  logic                      take, store;
  logic signed [VALUE_W-1:0] v, ca, cb;
  logic signed [VALUE_W-1:0] va_cand, vb_cand;
  logic [CW-1:0]             va_vote, vb_vote;

  assign in_stall = hold;
  assign take     = in_valid && !hold;
  assign v        = in_item.value;
  assign store    = (count_r < CW'(DEPTH));
  assign ca       = (count_r == '0) ? v : cand_a_r;
  assign cb       = (count_r == '0) ? v : cand_b_r;

  assign wr_en   = take && store;
  assign wr_addr = count_r[AW-1:0];
  assign wr_data = $unsigned(v);

  always_comb begin
    va_cand = ca;
    vb_cand = cb;
    va_vote = votes_a_r;
    vb_vote = votes_b_r;
    if ((v == ca || votes_a_r == '0) && v != cb) begin
      va_cand = v;
      va_vote = votes_a_r + CW'(1);
    end else if (v == cb || votes_b_r == '0) begin
      vb_cand = v;
      vb_vote = votes_b_r + CW'(1);
    end else begin
      va_vote = votes_a_r - CW'(1);
      vb_vote = votes_b_r - CW'(1);
    end
  end

  always_comb begin
    cand_a_nxt  = cand_a_r;
    cand_b_nxt  = cand_b_r;
    votes_a_nxt = votes_a_r;
    votes_b_nxt = votes_b_r;
    count_nxt   = count_r;
    drop_nxt    = drop_r;
    if (take) begin
      if (store) begin
        cand_a_nxt  = va_cand;
        cand_b_nxt  = vb_cand;
        votes_a_nxt = va_vote;
        votes_b_nxt = vb_vote;
        count_nxt   = count_r + CW'(1);
      end else begin
        drop_nxt = 1'b1;
      end
    end
    push              = take && in_item.last;
    push_job.cand_a   = cand_a_nxt;
    push_job.cand_b   = cand_b_nxt;
    push_job.overflow = drop_nxt;
    push_n            = count_nxt;
    // Sequence closes: start the next one clean.
    if (push) begin
      cand_a_nxt  = '0;
      cand_b_nxt  = '0;
      votes_a_nxt = '0;
      votes_b_nxt = '0;
      count_nxt   = '0;
      drop_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_a_r  <= '0;
      cand_b_r  <= '0;
      votes_a_r <= '0;
      votes_b_r <= '0;
      count_r   <= '0;
      drop_r    <= 1'b0;
    end else begin
      cand_a_r  <= cand_a_nxt;
      cand_b_r  <= cand_b_nxt;
      votes_a_r <= votes_a_nxt;
      votes_b_r <= votes_b_nxt;
      count_r   <= count_nxt;
      drop_r    <= drop_nxt;
    end
  end

endmodule

/* rtl/tcmv_back.sv */
module tcmv_back #(
  parameter int DEPTH = tcmv_pkg::DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_pop,
  input  tcmv_pkg::job_t               job,
  input  logic [CW-1:0]                job_n,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  input  logic [tcmv_pkg::VALUE_W-1:0] rd_data,
  output logic                         walking,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tcmv_pkg::out_item_t          out_item
);

  import tcmv_pkg::*;

  back_state_t state_r, state_nxt;

  logic signed [VALUE_W-1:0] cand_a_r, cand_a_nxt;
  logic signed [VALUE_W-1:0] cand_b_r, cand_b_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [CW-1:0]             n_r, n_nxt;
  logic [CW-1:0]             pos_r, pos_nxt;
  logic [CW-1:0]             tally_a_r, tally_a_nxt;
  logic [CW-1:0]             tally_b_r, tally_b_nxt;
  logic                      rd_vld_r;
  logic                      qa_r, qa_nxt;
  logic                      qb_r, qb_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;
  logic                      out_free;
  logic [CW+1:0]             ta_x3, tb_x3, n_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign walking   = (state_r == BK_WALK) || (state_r == BK_FLUSH);
  assign rd_addr   = pos_r[AW-1:0];

  // tally > floor(n/3) holds exactly when 3 * tally > n.
  assign ta_x3 = ({2'b00, tally_a_r} << 1) + {2'b00, tally_a_r};
  assign tb_x3 = ({2'b00, tally_b_r} << 1) + {2'b00, tally_b_r};
  assign n_ext = {2'b00, n_r};

  always_comb begin
    state_nxt     = state_r;
    cand_a_nxt    = cand_a_r;
    cand_b_nxt    = cand_b_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    tally_a_nxt   = tally_a_r;
    tally_b_nxt   = tally_b_r;
    qa_nxt        = qa_r;
    qb_nxt        = qb_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    job_pop       = 1'b0;
    rd_en         = 1'b0;

    // Count the word read in the previous cycle.
    if (rd_vld_r) begin
      if ($signed(rd_data) == cand_a_r) begin
        tally_a_nxt = tally_a_r + CW'(1);
      end else if ($signed(rd_data) == cand_b_r) begin
        tally_b_nxt = tally_b_r + CW'(1);
      end
    end

    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          job_pop     = 1'b1;
          cand_a_nxt  = job.cand_a;
          cand_b_nxt  = job.cand_b;
          ovf_nxt     = job.overflow;
          n_nxt       = job_n;
          pos_nxt     = '0;
          tally_a_nxt = '0;
          tally_b_nxt = '0;
          state_nxt   = BK_WALK;
        end
      end
      BK_WALK: begin
        rd_en = 1'b1;
        if ((pos_r + CW'(1)) == n_r) begin
          state_nxt = BK_FLUSH;
        end else begin
          pos_nxt = pos_r + CW'(1);
        end
      end
      BK_FLUSH: begin
        state_nxt = BK_DECIDE;
      end
      BK_DECIDE: begin
        qa_nxt    = (ta_x3 > n_ext);
        qb_nxt    = (tb_x3 > n_ext);
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.overflow  = ovf_r;
          out_item_nxt.final_res = 1'b1;
          state_nxt              = BK_IDLE;
          if (qa_r) begin
            out_item_nxt.element       = cand_a_r;
            out_item_nxt.element_valid = 1'b1;
            out_item_nxt.final_res     = !qb_r;
            if (qb_r) begin
              state_nxt = BK_EMIT_B;
            end
          end else if (qb_r) begin
            out_item_nxt.element       = cand_b_r;
            out_item_nxt.element_valid = 1'b1;
          end else begin
            out_item_nxt.element       = '0;
            out_item_nxt.element_valid = 1'b0;
          end
        end
      end
      BK_EMIT_B: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_item_nxt.element       = cand_b_r;
          out_item_nxt.element_valid = 1'b1;
          out_item_nxt.final_res     = 1'b1;
          out_item_nxt.overflow      = ovf_r;
          state_nxt                  = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_a_r   <= cand_a_nxt;
    cand_b_r   <= cand_b_nxt;
    ovf_r      <= ovf_nxt;
    n_r        <= n_nxt;
    pos_r      <= pos_nxt;
    tally_a_r  <= tally_a_nxt;
    tally_b_r  <= tally_b_nxt;
    qa_r       <= qa_nxt;
    qb_r       <= qb_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

/* rtl/two_candidate_majority_vote.sv */
// Finds every value that occurs more than floor(n/3) times in a sequence of
// signed 32-bit values closed by last. The front end takes one value per
// cycle while in_stall is low, stores it and runs the two-candidate vote; the
// closing transaction hands the two candidates to the back end, which walks
// the store once (one read per cycle on the single RAM read port, then a
// flush state to count the last word and a decide state) and then delivers up
// to two results, candidate A first. With no qualifier a single result with
// element_valid low is returned. Input stalls after the closing transaction
// while its job waits in the queue or the store is walked; a result still
// held by out_stall when the next sequence closes delays that sequence's walk.
// Values past DEPTH are dropped and every result of that sequence carries
// overflow.
module two_candidate_majority_vote #(
  parameter int DEPTH = tcmv_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tcmv_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output tcmv_pkg::out_item_t out_item
);

  import tcmv_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QW = $bits(job_t) + CW;

  logic               hold, walking;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data, rd_data;
  logic               push, pop, q_full, q_valid;
  job_t               push_job, pop_job;
  logic [CW-1:0]      push_n, pop_n;
  logic [QW-1:0]      q_in, q_out;

  assign hold = q_valid || q_full || walking;
  assign q_in = {push_job, push_n};
  assign {pop_job, pop_n} = q_out;

  tcmv_front #(.DEPTH(DEPTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .hold     (hold),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .push     (push),
    .push_job (push_job),
    .push_n   (push_n)
  );

  tcmv_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tcmv_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  tcmv_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_pop   (pop),
    .job       (pop_job),
    .job_n     (pop_n),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .walking   (walking),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

/* bench/two_candidate_majority_vote_test.sv */
`timescale 1ns / 100ps

module two_candidate_majority_vote_test;
  import tcmv_pkg::*;

  localparam int DUT_DEPTH    = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 300;
  // longest quiet stretch is a full-store walk plus a receiver stall
  localparam int STALL_LIMIT  = 5000;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    bit                        last;
    int                        reps;
    bit                        typed;
    out_item_t                 res;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // predictor state
  logic [VALUE_W-1:0] seq_store [DUT_DEPTH];
  logic [VALUE_W-1:0] lead_a, lead_b;
  int                 votes_a, votes_b, seq_len;
  bit                 seq_dropped;

  out_item_t expected_results[$];
  int        mismatch_count = 0;
  int        burst_left     = 0;
  int        quiet_cycles   = 0;
  logic [9:0] stall_phase   = '0;

  int seq_count = 0, value_count = 0, longest_seq = 0, result_count = 0;
  int pair_count = 0, empty_count = 0, truncated_count = 0;

  two_candidate_majority_vote #(
    .DEPTH(DUT_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic out_item_t mk_res(input logic [VALUE_W-1:0] elem, input bit vld,
                                       input bit ovf);
    out_item_t r;
    r.element       = elem;
    r.element_valid = vld;
    r.final_res     = 1'b1;
    r.overflow      = ovf;
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      3:       return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Run one value through the two-candidate vote; on last, count the store
  // and return the winners, candidate A first.
  task automatic vote_and_tally(input in_item_t it, output out_item_t found[$]);
    logic [VALUE_W-1:0] v;
    int        tally_a, tally_b, limit;
    bit        qa, qb;
    out_item_t r;
    found = {};
    v = it.value;
    value_count++;
    if (seq_len < DUT_DEPTH) begin
      if (seq_len == 0) begin
        lead_a = v;
        lead_b = v;
      end
      seq_store[seq_len] = v;
      seq_len++;
      if ((v == lead_a || votes_a == 0) && v != lead_b) begin
        lead_a = v;
        votes_a++;
      end else if (v == lead_b || votes_b == 0) begin
        lead_b = v;
        votes_b++;
      end else begin
        votes_a--;
        votes_b--;
      end
    end else begin
      seq_dropped = 1'b1;
    end
    if (!it.last) return;

    tally_a = 0;
    tally_b = 0;
    for (int k = 0; k < seq_len; k++) begin
      if (seq_store[k] == lead_a) tally_a++;
      else if (seq_store[k] == lead_b) tally_b++;
    end
    limit = seq_len / 3;
    qa = tally_a > limit;
    qb = tally_b > limit;
    if (qa) begin
      r = mk_res(lead_a, 1'b1, seq_dropped);
      r.final_res = !qb;
      found.push_back(r);
    end
    if (qb) found.push_back(mk_res(lead_b, 1'b1, seq_dropped));
    if (!qa && !qb) begin
      found.push_back(mk_res('0, 1'b0, seq_dropped));
      empty_count++;
    end
    if (qa && qb) pair_count++;
    if (seq_dropped) truncated_count++;
    seq_count++;
    result_count += found.size();
    if (seq_len > longest_seq) longest_seq = seq_len;

    lead_a      = '0;
    lead_b      = '0;
    votes_a     = 0;
    votes_b     = 0;
    seq_len     = 0;
    seq_dropped = 1'b0;
  endtask

  // Offer one transaction, with bursts and gaps, and queue its results once taken.
  task automatic send_value(input in_item_t it, input bit typed, input out_item_t typed_res);
    int        idle;
    out_item_t found[$];
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 48);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (idle > 0) begin
        in_valid <= 1'b0;
        repeat (idle) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    vote_and_tally(it, found);
    if (typed) expected_results.push_back(typed_res);
    else foreach (found[i]) expected_results.push_back(found[i]);
  endtask

  // Receiver stall pattern: free, random, periodic, then heavy, per window.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    case (stall_phase[9:8])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 1) == 0);
      2'd2:    out_stall <= (stall_phase[2:0] < 3'd5);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, element %0d",
                                  out_item.element));
      end else begin
        want = expected_results.pop_front();
        if (out_item.element !== want.element)
          report_mismatch($sformatf("element %0d, want %0d", out_item.element, want.element));
        if (out_item.element_valid !== want.element_valid)
          report_mismatch($sformatf("element_valid %b, want %b",
                                    out_item.element_valid, want.element_valid));
        if (out_item.final_res !== want.final_res)
          report_mismatch($sformatf("final_res %b, want %b", out_item.final_res,
                                    want.final_res));
        if (out_item.overflow !== want.overflow)
          report_mismatch($sformatf("overflow %b, want %b", out_item.overflow,
                                    want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction, %0d results pending",
               STALL_LIMIT, expected_results.size());
      $display("two_candidate_majority_vote verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t          directed[$];
    in_item_t           item;
    logic [VALUE_W-1:0] hot_a, hot_b;
    int                 random_sent, len, w_a, w_b, pick;

    lead_a      = '0;
    lead_b      = '0;
    votes_a     = 0;
    votes_b     = 0;
    seq_len     = 0;
    seq_dropped = 1'b0;

    // single values at the extremes, and zero against the cleared candidates
    directed.push_back('{32'sh7FFF_FFFF, 1'b1, 1, 1'b1, mk_res(32'h7FFF_FFFF, 1'b1, 1'b0)});
    directed.push_back('{32'sh8000_0000, 1'b1, 1, 1'b1, mk_res(32'h8000_0000, 1'b1, 1'b0)});
    directed.push_back('{32'sh0,         1'b1, 1, 1'b1, mk_res(32'h0, 1'b1, 1'b0)});
    // three distinct values: nobody wins
    directed.push_back('{32'sd1, 1'b0, 1, 1'b0, '0});
    directed.push_back('{32'sd2, 1'b0, 1, 1'b0, '0});
    directed.push_back('{32'sd3, 1'b1, 1, 1'b1, mk_res('0, 1'b0, 1'b0)});
    // two winners
    directed.push_back('{32'sd1, 1'b0, 2, 1'b0, '0});
    directed.push_back('{32'sd2, 1'b0, 1, 1'b0, '0});
    directed.push_back('{32'sd2, 1'b1, 1, 1'b0, '0});
    // only the second candidate wins
    directed.push_back('{-32'sd1, 1'b0, 2, 1'b0, '0});
    directed.push_back('{32'sd5,  1'b1, 1, 1'b0, '0});
    // bit patterns with a third value to force decrements
    directed.push_back('{32'sh5555_5555, 1'b0, 3, 1'b0, '0});
    directed.push_back('{32'shAAAA_AAAA, 1'b0, 3, 1'b0, '0});
    directed.push_back('{32'sh1234_5678, 1'b0, 1, 1'b0, '0});
    directed.push_back('{32'shFFFF_FFFF, 1'b1, 1, 1'b0, '0});
    // store full: the value after DEPTH is dropped but still closes
    directed.push_back('{32'sd5, 1'b1, DUT_DEPTH + 1, 1'b1, mk_res(32'd5, 1'b1, 1'b1)});
    // the drop flag clears for the next sequence
    directed.push_back('{32'sd42, 1'b1, 1, 1'b1, mk_res(32'd42, 1'b1, 1'b0)});

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      for (int k = 0; k < directed[i].reps; k++) begin
        item.value = directed[i].value;
        item.last  = directed[i].last && (k == directed[i].reps - 1);
        send_value(item, directed[i].typed && item.last, directed[i].res);
      end
    end

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 11) == 0) begin
        len = 1;
      end else begin
        len = $urandom_range(2, 30);
      end
      hot_a = pick_value();
      hot_b = pick_value();
      w_a   = $urandom_range(0, 70);
      w_b   = $urandom_range(0, 100 - w_a);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < w_a) item.value = hot_a;
        else if (pick < w_a + w_b) item.value = hot_b;
        else item.value = pick_value();
        item.last = (k == len - 1);
        send_value(item, 1'b0, '0);
        random_sent++;
      end
    end
    in_valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d sequences, %0d values (longest %0d), %0d results checked.",
             seq_count, value_count, longest_seq, result_count);
    $display("Two winners in %0d, no winner in %0d, truncated in %0d; %0d mismatches.",
             pair_count, empty_count, truncated_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("two_candidate_majority_vote verification clean");
    end else begin
      $display("two_candidate_majority_vote verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tcmv_pkg.sv
rtl/tcmv_ram.sv
rtl/tcmv_queue.sv
rtl/tcmv_front.sv
rtl/tcmv_back.sv
rtl/two_candidate_majority_vote.sv
bench/two_candidate_majority_vote_test.sv
